FILE: rtl/core/mmwg_pkg.sv
// Shared types, constants and arithmetic helpers of the waveform generator.
`default_nettype none
package mmwg_pkg;

  localparam int IdxW      = 24;
  localparam int AmpW      = 16;
  localparam int SineDepth = 1024;
  localparam int OffW      = $clog2(SineDepth);
  localparam int AddrW     = OffW + 1;
  localparam int SineShift = $clog2(4 * SineDepth);
  localparam int LenW      = 25;
  localparam int RateW     = 20;
  localparam int FreqW     = 24;
  localparam int FracW     = 8;
  localparam int CfgW      = 25;
  localparam int DivW      = RateW + FracW;
  localparam int NumW      = 48;
  localparam int CntW      = $clog2(DivW);
  localparam int QsW       = AmpW + 1;
  localparam int ArW       = AmpW + 3;
  localparam int RampShift = AmpW - 1;
  localparam int SawShift  = AmpW;

  localparam logic [AmpW-1:0]       AmpMax      = {1'b0, {(AmpW-1){1'b1}}};
  localparam logic [AmpW-1:0]       AmpMin      = {1'b1, {(AmpW-1){1'b0}}};
  localparam logic signed [ArW-1:0] FsAr        = ArW'(2 ** (AmpW - 1));
  localparam logic [2:0]            ModeReset   = 3'd0;
  localparam logic [LenW-1:0]       LenReset    = LenW'(1);
  localparam logic [RateW-1:0]      RateReset   = RateW'(44100);
  localparam logic [FreqW-1:0]      FreqReset   = FreqW'(256);
  localparam logic [DivW-1:0]       PeriodReset = DivW'(44100);
  localparam longint unsigned       HalfPiQ30   = 64'd1686629713;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_LENGTH = 2'd1,
    REG_RATE   = 2'd2,
    REG_FREQ   = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_RAMP_UP   = 3'd0,
    MODE_RAMP_DOWN = 3'd1,
    MODE_SINE      = 3'd2,
    MODE_SAW       = 3'd3,
    MODE_RSAW      = 3'd4
  } mode_e;

  typedef struct packed {
    mode_e op;
    logic  special;
    logic  last;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [NumW-1:0] num;
    logic [DivW-1:0] div;
  } item_t;

  typedef struct packed {
    logic [LenW-1:0] ramp_d;
    logic [DivW-1:0] period;
    logic [DivW-1:0] cycle;
  } cfg_t;

  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [NumW-1:0] nq;
  } div_state_t;

  typedef logic [AmpW-2:0] sine_rom_t [0:SineDepth];

  function automatic div_state_t div_step(div_state_t s, logic [DivW-1:0] d);
    logic [DivW:0] part;
    div_state_t    r;
    part = {s.rem, s.nq[NumW-1]};
    r.nq = {s.nq[NumW-2:0], 1'b0};
    if (part >= {1'b0, d}) begin
      part    = part - {1'b0, d};
      r.nq[0] = 1'b1;
    end
    r.rem = part[DivW-1:0];
    return r;
  endfunction

  function automatic logic [AmpW-1:0] sat_amp(logic signed [ArW-1:0] v);
    if (v > $signed({3'b000, AmpMax})) begin
      return AmpMax;
    end else if (v < $signed({3'b111, AmpMin})) begin
      return AmpMin;
    end
    return v[AmpW-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   prod;
    longint            s;
    longint            v;
    longint            maxa;
    maxa = longint'(AmpMax);
    for (int k = 0; k <= SineDepth; k++) begin
      x    = (HalfPiQ30 * 64'(k)) / 64'(SineDepth);
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        prod = (term * x2) >> 30;
        case (n)
          1:       term = prod / 64'd6;
          2:       term = prod / 64'd20;
          3:       term = prod / 64'd42;
          4:       term = prod / 64'd72;
          5:       term = prod / 64'd110;
          6:       term = prod / 64'd156;
          default: term = prod / 64'd210;
        endcase
        if ((n % 2) == 1) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      v = (s * maxa + (64'sd1 <<< 29)) >>> 30;
      if (v > maxa) v = maxa;
      rom[k] = v[AmpW-2:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage
`default_nettype wire

FILE: rtl/core/multi_mode_waveform_generator_unit.sv
// Top level of the multi-mode waveform generator.
// Throughput: one sample per cycle while busy_o is low; the two 48-stage divider pipelines set the latency.
// After a write to sample_rate or frequency_q8, busy_o stays high while the sawtooth
// period is divided out one bit a cycle; no transfer waits on the receiver.
// Reset is asynchronous, active low, and loads the register defaults (period 44100).
`default_nettype none
module multi_mode_waveform_generator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [mmwg_pkg::IdxW-1:0] sample_index_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [mmwg_pkg::CfgW-1:0] cfg_wdata_i,
  output logic                      done_o,
  output logic [mmwg_pkg::AmpW-1:0] amplitude_o,
  output logic                      period_error_o,
  output logic                      last_sample_o
);
  import mmwg_pkg::*;

  logic  push;
  item_t push_item;
  logic  fifo_full;
  logic  fifo_valid;
  item_t fifo_item;
  cfg_t  cfg;

  mmwg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .sample_index_i (sample_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fifo_full_i    (fifo_full),
    .busy_o         (busy_o),
    .push_o         (push),
    .item_o         (push_item),
    .cfg_o          (cfg)
  );

  mmwg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_valid),
    .valid_o (fifo_valid),
    .item_o  (fifo_item)
  );

  mmwg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (fifo_valid),
    .item_i         (fifo_item),
    .cfg_i          (cfg),
    .done_o         (done_o),
    .amplitude_o    (amplitude_o),
    .period_error_o (period_error_o),
    .last_sample_o  (last_sample_o)
  );

endmodule
`default_nettype wire

FILE: rtl/core/mmwg_fifo.sv
// Two-entry queue between the front end and the arithmetic back end.
`default_nettype none
module mmwg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mmwg_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mmwg_pkg::item_t item_o
);
  import mmwg_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = |count_q;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = (pop_i && valid_o) ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i && valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mmwg_front.sv
// Front end: configuration registers, period precompute and item classification.
`default_nettype none
module mmwg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mmwg_pkg::IdxW-1:0]     sample_index_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [mmwg_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          fifo_full_i,
  output logic                          busy_o,
  output logic                          push_o,
  output mmwg_pkg::item_t               item_o,
  output mmwg_pkg::cfg_t                cfg_o
);
  import mmwg_pkg::*;

  typedef enum logic [2:0] {
    PS_IDLE = 3'b001,
    PS_LOAD = 3'b010,
    PS_CALC = 3'b100
  } per_state_e;

  logic [2:0]       mode_q;
  logic [LenW-1:0]  len_q;
  logic [RateW-1:0] rate_q;
  logic [FreqW-1:0] freq_q;
  logic [DivW-1:0]  period_q, period_d;
  per_state_e       state_q, state_d;
  div_state_t       pdiv_q, pdiv_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rf_wr;
  logic             per_err;
  logic [NumW-1:0]  prod;
  logic [DivW-1:0]  cycle;

  assign rf_wr   = cfg_we_i && (cfg_idx_i == REG_RATE || cfg_idx_i == REG_FREQ);
  assign cycle   = {rate_q, {FracW{1'b0}}};
  assign per_err = (freq_q == '0) || (period_q < DivW'(2));
  assign prod    = NumW'(sample_index_i) * NumW'(freq_q);
  assign busy_o  = (state_q != PS_IDLE) || fifo_full_i;
  assign push_o  = start_i && !busy_o;

  assign cfg_o.ramp_d = len_q - LenW'(1);
  assign cfg_o.period = period_q;
  assign cfg_o.cycle  = cycle;

  always_comb begin
    state_d  = state_q;
    pdiv_d   = pdiv_q;
    cnt_d    = cnt_q;
    period_d = period_q;
    if (rf_wr) begin
      state_d = PS_LOAD;
    end else begin
      unique case (state_q)
        PS_LOAD: begin
          pdiv_d  = {DivW'(0), rate_q, {FracW{1'b0}}, {(NumW-DivW){1'b0}}};
          cnt_d   = '0;
          state_d = PS_CALC;
        end
        PS_CALC: begin
          pdiv_d = div_step(pdiv_q, DivW'(freq_q));
          cnt_d  = cnt_q + CntW'(1);
          if (cnt_q == CntW'(DivW - 1)) begin
            state_d  = PS_IDLE;
            period_d = pdiv_d.nq[DivW-1:0];
          end
        end
        default: begin
          state_d = PS_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    item_o.tag.last    = ({1'b0, sample_index_i} + LenW'(1)) == len_q;
    item_o.tag.op      = MODE_RAMP_UP;
    item_o.tag.special = 1'b1;
    item_o.num         = '0;
    item_o.div         = DivW'(1);
    unique case (mode_q)
      MODE_RAMP_UP, MODE_RAMP_DOWN: begin
        item_o.tag.op      = (mode_q == MODE_RAMP_UP) ? MODE_RAMP_UP : MODE_RAMP_DOWN;
        item_o.tag.special = len_q <= LenW'(1);
        item_o.num         = NumW'(sample_index_i);
      end
      MODE_SINE: begin
        item_o.tag.op      = MODE_SINE;
        item_o.tag.special = rate_q == '0;
        item_o.num         = prod;
        item_o.div         = cycle;
      end
      MODE_SAW, MODE_RSAW: begin
        item_o.tag.op      = (mode_q == MODE_SAW) ? MODE_SAW : MODE_RSAW;
        item_o.tag.special = per_err;
        item_o.num         = NumW'(sample_index_i);
        item_o.div         = period_q;
      end
      default: begin
        item_o.tag.op = MODE_RAMP_UP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeReset;
      len_q    <= LenReset;
      rate_q   <= RateReset;
      freq_q   <= FreqReset;
      period_q <= PeriodReset;
      state_q  <= PS_IDLE;
      pdiv_q   <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_MODE:   mode_q <= cfg_wdata_i[2:0];
          REG_LENGTH: len_q  <= cfg_wdata_i[LenW-1:0];
          REG_RATE:   rate_q <= cfg_wdata_i[RateW-1:0];
          REG_FREQ:   freq_q <= cfg_wdata_i[FreqW-1:0];
          default:    mode_q <= mode_q;
        endcase
      end
      period_q <= period_d;
      state_q  <= state_d;
      pdiv_q   <= pdiv_d;
      cnt_q    <= cnt_d;
    end
  end

  a_rf_wr_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr |=> state_q == PS_LOAD)
    else $error("period precompute not restarted after write");

  a_load_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PS_LOAD && !rf_wr) |=> state_q == PS_CALC)
    else $error("period precompute did not start");

  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> state_q == PS_IDLE)
    else $error("item taken during period precompute");

endmodule
`default_nettype wire

FILE: rtl/core/mmwg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag alongside.
`default_nettype none
module mmwg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [mmwg_pkg::NumW-1:0] in_num_i,
  input  logic [mmwg_pkg::DivW-1:0] in_div_i,
  input  mmwg_pkg::tag_t            in_tag_i,
  output logic                      out_valid_o,
  output logic [mmwg_pkg::NumW-1:0] out_quot_o,
  output logic [mmwg_pkg::DivW-1:0] out_rem_o,
  output mmwg_pkg::tag_t            out_tag_o
);
  import mmwg_pkg::*;

  logic            vld_q [NumW];
  div_state_t      st_q  [NumW];
  logic [DivW-1:0] dv_q  [NumW];
  tag_t            tag_q [NumW];
  div_state_t      first_st;

  assign first_st = {DivW'(0), in_num_i};

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[s] <= 1'b0;
        end else begin
          vld_q[s] <= in_valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        st_q[s]  <= div_step(first_st, in_div_i);
        dv_q[s]  <= in_div_i;
        tag_q[s] <= in_tag_i;
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[s] <= 1'b0;
        end else begin
          vld_q[s] <= vld_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        st_q[s]  <= div_step(st_q[s-1], dv_q[s-1]);
        dv_q[s]  <= dv_q[s-1];
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  assign out_valid_o = vld_q[NumW-1];
  assign out_quot_o  = st_q[NumW-1].nq;
  assign out_rem_o   = st_q[NumW-1].rem;
  assign out_tag_o   = tag_q[NumW-1];

endmodule
`default_nettype wire

FILE: rtl/core/mmwg_back.sv
// Back end: two divider pipelines, operand rework, sine lookup and output stage.
`default_nettype none
module mmwg_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  mmwg_pkg::item_t           item_i,
  input  mmwg_pkg::cfg_t            cfg_i,
  output logic                      done_o,
  output logic [mmwg_pkg::AmpW-1:0] amplitude_o,
  output logic                      period_error_o,
  output logic                      last_sample_o
);
  import mmwg_pkg::*;

  logic             a_valid;
  logic [NumW-1:0]  a_quot;
  logic [DivW-1:0]  a_rem;
  tag_t             a_tag;
  logic [NumW-1:0]  m_num_d;
  logic [DivW-1:0]  m_div_d;
  logic [DivW-1:0]  pd;
  logic             m_valid_q;
  logic [NumW-1:0]  m_num_q;
  logic [DivW-1:0]  m_div_q;
  tag_t             m_tag_q;
  logic             b_valid;
  logic [NumW-1:0]  b_quot;
  logic [DivW-1:0]  b_rem;
  tag_t             b_tag;
  logic [QsW-1:0]   qs;
  logic signed [ArW-1:0] qs_s;
  logic [AmpW-1:0]  p1_amp_d;
  logic             p1_sine_d;
  logic             p1_err_d;
  logic [AddrW-1:0] p1_addr_d;
  logic [OffW-1:0]  off;
  logic             p1_valid_q;
  logic [AmpW-1:0]  p1_amp_q;
  logic             p1_sine_q;
  logic             p1_err_q;
  logic             p1_neg_q;
  logic             p1_last_q;
  mode_e            p1_op_q;
  logic [AddrW-1:0] p1_addr_q;
  logic             p2_valid_q;
  logic [AmpW-1:0]  p2_amp_q;
  logic             p2_sine_q;
  logic             p2_err_q;
  logic             p2_neg_q;
  logic             p2_last_q;
  logic [AmpW-2:0]  p2_rom_q;
  logic             out_valid_q;
  logic [AmpW-1:0]  out_amp_q;
  logic             out_err_q;
  logic             out_last_q;

  mmwg_div u_div_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_valid_i),
    .in_num_i    (item_i.num),
    .in_div_i    (item_i.div),
    .in_tag_i    (item_i.tag),
    .out_valid_o (a_valid),
    .out_quot_o  (a_quot),
    .out_rem_o   (a_rem),
    .out_tag_o   (a_tag)
  );

  assign pd = cfg_i.period - DivW'(1);

  always_comb begin
    unique case (a_tag.op)
      MODE_SINE: begin
        m_num_d = NumW'({a_rem, {SineShift{1'b0}}});
        m_div_d = cfg_i.cycle;
      end
      MODE_SAW, MODE_RSAW: begin
        m_num_d = NumW'({a_rem, {SawShift{1'b0}}}) + NumW'(pd >> 1);
        m_div_d = pd;
      end
      default: begin
        m_num_d = NumW'({a_quot[IdxW-1:0], {RampShift{1'b0}}}) + NumW'(cfg_i.ramp_d >> 1);
        m_div_d = DivW'(cfg_i.ramp_d);
      end
    endcase
  end

  mmwg_div u_div_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m_valid_q),
    .in_num_i    (m_num_q),
    .in_div_i    (m_div_q),
    .in_tag_i    (m_tag_q),
    .out_valid_o (b_valid),
    .out_quot_o  (b_quot),
    .out_rem_o   (b_rem),
    .out_tag_o   (b_tag)
  );

  assign qs   = (|b_quot[NumW-1:QsW]) ? {QsW{1'b1}} : b_quot[QsW-1:0];
  assign qs_s = $signed({2'b00, qs});
  assign off  = b_quot[OffW-1:0];

  always_comb begin
    p1_amp_d  = '0;
    p1_sine_d = 1'b0;
    p1_err_d  = 1'b0;
    p1_addr_d = b_quot[OffW] ? (AddrW'(SineDepth) - {1'b0, off}) : {1'b0, off};
    unique case (b_tag.op)
      MODE_RAMP_DOWN: p1_amp_d = b_tag.special ? AmpMax : sat_amp(FsAr - qs_s);
      MODE_SINE:      p1_sine_d = !b_tag.special;
      MODE_SAW: begin
        p1_amp_d = b_tag.special ? '0 : sat_amp(qs_s - FsAr);
        p1_err_d = b_tag.special;
      end
      MODE_RSAW: begin
        p1_amp_d = b_tag.special ? '0 : sat_amp(FsAr - qs_s);
        p1_err_d = b_tag.special;
      end
      default:        p1_amp_d = b_tag.special ? '0 : sat_amp(qs_s);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      m_valid_q   <= a_valid;
      p1_valid_q  <= b_valid;
      p2_valid_q  <= p1_valid_q;
      out_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_num_q    <= m_num_d;
    m_div_q    <= m_div_d;
    m_tag_q    <= a_tag;
    p1_amp_q   <= p1_amp_d;
    p1_sine_q  <= p1_sine_d;
    p1_err_q   <= p1_err_d;
    p1_neg_q   <= b_quot[OffW+1];
    p1_last_q  <= b_tag.last;
    p1_op_q    <= b_tag.op;
    p1_addr_q  <= p1_addr_d;
    p2_amp_q   <= p1_amp_q;
    p2_sine_q  <= p1_sine_q;
    p2_err_q   <= p1_err_q;
    p2_neg_q   <= p1_neg_q;
    p2_last_q  <= p1_last_q;
    p2_rom_q   <= SineRom[p1_addr_q];
    out_err_q  <= p2_err_q;
    out_last_q <= p2_last_q;
    if (p2_sine_q) begin
      out_amp_q <= p2_neg_q ? -{1'b0, p2_rom_q} : {1'b0, p2_rom_q};
    end else begin
      out_amp_q <= p2_amp_q;
    end
  end

  assign done_o         = out_valid_q;
  assign amplitude_o    = out_amp_q;
  assign period_error_o = out_err_q;
  assign last_sample_o  = out_last_q;

  a_sine_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && p1_sine_q) |-> p1_addr_q <= AddrW'(SineDepth))
    else $error("sine table address out of range");

  a_err_saw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && p1_err_q) |-> (p1_op_q == MODE_SAW || p1_op_q == MODE_RSAW))
    else $error("period error outside sawtooth modes");

  a_ramp_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && p1_op_q == MODE_RAMP_UP) |-> !p1_amp_q[AmpW-1])
    else $error("negative ramp-up amplitude");

endmodule
`default_nettype wire
